// ----- rtl/core/incremental_pid_speed_regulator_defines.svh -----
// Assertion helpers shared by the speed regulator modules.
`ifndef INCREMENTAL_PID_SPEED_REGULATOR_DEFINES_SVH
`define INCREMENTAL_PID_SPEED_REGULATOR_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define IPID_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only outside reset.
`define IPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ipid_pkg.sv -----
`timescale 1ns / 1ps

package ipid_pkg;

  // Field and register widths.
  localparam int GAIN_W     = 24;
  localparam int SCALE_W    = 16;
  localparam int LIMIT_W    = 15;
  localparam int DUTY_W     = 16;
  localparam int SPEED_W    = 16;
  localparam int CODE_W     = 16;
  localparam int SPP_W      = SCALE_W + CODE_W;
  localparam int SCALE_FRAC = 12;
  localparam int GAIN_FRAC  = 16;

  // Error is held in 34 bits; multiplier operands are cut into a 17-bit
  // unsigned low chunk and an 18-bit signed high chunk.
  localparam int ERR_W  = 34;
  localparam int OPND_W = 35;
  localparam int LO_W   = 17;
  localparam int HI_W   = OPND_W - LO_W;
  localparam int PROD_W = GAIN_W + HI_W;
  localparam int ACC_W  = 62;

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [CFG_AW-3:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_SCALE = 3'd3,
    REG_ILIM  = 3'd4,
    REG_DMIN  = 3'd5,
    REG_DMAX  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [SCALE_W-1:0]       scale;
    logic [LIMIT_W-1:0]       ilimit;
    logic [DUTY_W-1:0]        duty_min;
    logic [DUTY_W-1:0]        duty_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kp:       24'sd26477,
    ki:       24'sd0,
    kd:       24'sd0,
    scale:    16'd5366,
    ilimit:   15'd100,
    duty_min: 16'd3,
    duty_max: 16'd65535
  };

  // Microcode fields.
  typedef enum logic [1:0] {
    W_NONE     = 2'd0,
    W_INPUT    = 2'd1,
    W_OUT_SLOT = 2'd2
  } wait_t;

  typedef enum logic [1:0] {
    A_SCALE = 2'd0,
    A_KP    = 2'd1,
    A_KI    = 2'd2,
    A_KD    = 2'd3
  } mul_a_t;

  typedef enum logic [2:0] {
    B_CODE    = 3'd0,
    B_ERR_LO  = 3'd1,
    B_ERR_HI  = 3'd2,
    B_INT_LO  = 3'd3,
    B_INT_HI  = 3'd4,
    B_DIFF_LO = 3'd5,
    B_DIFF_HI = 3'd6
  } mul_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD      = 2'd0,
    ACC_LOAD_DUTY = 2'd1,
    ACC_ADD_LO    = 2'd2,
    ACC_ADD_HI    = 2'd3
  } acc_op_t;

  localparam int PROG_LEN = 10;
  localparam int STEP_W   = $clog2(PROG_LEN);
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_ERR  = 4'd1;
  localparam step_t STEP_INT  = 4'd2;
  localparam step_t STEP_KPH  = 4'd3;
  localparam step_t STEP_KIL  = 4'd4;
  localparam step_t STEP_KIH  = 4'd5;
  localparam step_t STEP_KDL  = 4'd6;
  localparam step_t STEP_KDH  = 4'd7;
  localparam step_t STEP_LAST = 4'd8;
  localparam step_t STEP_OUT  = 4'd9;

  typedef struct packed {
    wait_t   wt;
    logic    jmp;
    step_t   target;
    logic    in_we;
    logic    mul_en;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    acc_op_t acc_op;
    logic    err_we;
    logic    int_we;
    logic    out_we;
  } ctl_t;

  localparam ctl_t CTL_NOP = '{
    wt:     W_NONE,
    jmp:    1'b0,
    target: STEP_IDLE,
    in_we:  1'b0,
    mul_en: 1'b0,
    mul_a:  A_SCALE,
    mul_b:  B_CODE,
    acc_op: ACC_HOLD,
    err_we: 1'b0,
    int_we: 1'b0,
    out_we: 1'b0
  };

  // Control store. Each gain product is added to the accumulator in the step
  // after it is formed; low chunks at weight one, high chunks shifted up by LO_W.
  function automatic ctl_t ucode(input step_t s);
    ctl_t c;
    c = CTL_NOP;
    unique case (s)
      STEP_IDLE: begin
        c.wt = W_INPUT; c.in_we = 1'b1;
        c.mul_en = 1'b1; c.mul_a = A_SCALE; c.mul_b = B_CODE;
      end
      STEP_ERR: begin
        c.err_we = 1'b1;
      end
      STEP_INT: begin
        c.int_we = 1'b1; c.acc_op = ACC_LOAD_DUTY;
        c.mul_en = 1'b1; c.mul_a = A_KP; c.mul_b = B_ERR_LO;
      end
      STEP_KPH: begin
        c.acc_op = ACC_ADD_LO;
        c.mul_en = 1'b1; c.mul_a = A_KP; c.mul_b = B_ERR_HI;
      end
      STEP_KIL: begin
        c.acc_op = ACC_ADD_HI;
        c.mul_en = 1'b1; c.mul_a = A_KI; c.mul_b = B_INT_LO;
      end
      STEP_KIH: begin
        c.acc_op = ACC_ADD_LO;
        c.mul_en = 1'b1; c.mul_a = A_KI; c.mul_b = B_INT_HI;
      end
      STEP_KDL: begin
        c.acc_op = ACC_ADD_HI;
        c.mul_en = 1'b1; c.mul_a = A_KD; c.mul_b = B_DIFF_LO;
      end
      STEP_KDH: begin
        c.acc_op = ACC_ADD_LO;
        c.mul_en = 1'b1; c.mul_a = A_KD; c.mul_b = B_DIFF_HI;
      end
      STEP_LAST: begin
        c.acc_op = ACC_ADD_HI;
      end
      STEP_OUT: begin
        c.wt = W_OUT_SLOT; c.out_we = 1'b1;
        c.jmp = 1'b1; c.target = STEP_IDLE;
      end
      default: begin
        c.jmp = 1'b1; c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/incremental_pid_speed_regulator.sv -----
`timescale 1ns / 1ps
// Incremental PID speed regulator with integral anti-windup.
// Input channel (in_valid/in_ready): one item per control sample, carrying
// the measured speed and the set-point code. Result channel
// (out_valid/out_ready): one item per input, the new clamped duty value.
// Gains, set-point scale, integral limit and duty bounds sit in an APB-style
// register file; write them only while the block is idle.
// Operation: a microcoded step counter runs a ten-step program over one shared
// 24x18 multiplier (set-point scaling plus two partial products per gain term),
// so a new item is taken only after the previous one has run the whole program
// and its result has been written. The multiplier, used in seven of the steps,
// sets the length of the program.
// If the receiver stalls, the result register holds its item; the next input
// item is still accepted and worked through, then waits in the last step
// until the result register frees up.
// Reset (rst_n, synchronous) loads the register defaults and clears the
// integral, the previous error, the last duty and the result flag.
module incremental_pid_speed_regulator
  import ipid_pkg::*;
#(
  parameter int FRAC_BITS   = 12,
  parameter int SPEED_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SPEED_W-1:0] in_measured_rpm,
  input  logic [CODE_W-1:0]  in_set_point_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DUTY_W-1:0]  out_duty_cycle
);

  cfg_t cfg;
  ctl_t ctl;
  logic out_free;

  // Configuration registers.
  ipid_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Microcode sequencer.
  ipid_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // Datapath and result register.
  ipid_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .ctl               (ctl),
    .in_measured_rpm   (in_measured_rpm),
    .in_set_point_code (in_set_point_code),
    .out_ready         (out_ready),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_duty_cycle    (out_duty_cycle)
  );

endmodule

// ----- rtl/core/ipid_cfg.sv -----
`timescale 1ns / 1ps

module ipid_cfg
  import ipid_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg    = cfg_r;

  // Register write decode; an index past the list is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_KP:    cfg_nxt.kp       = pwdata[GAIN_W-1:0];
        REG_KI:    cfg_nxt.ki       = pwdata[GAIN_W-1:0];
        REG_KD:    cfg_nxt.kd       = pwdata[GAIN_W-1:0];
        REG_SCALE: cfg_nxt.scale    = pwdata[SCALE_W-1:0];
        REG_ILIM:  cfg_nxt.ilimit   = pwdata[LIMIT_W-1:0];
        REG_DMIN:  cfg_nxt.duty_min = pwdata[DUTY_W-1:0];
        REG_DMAX:  cfg_nxt.duty_max = pwdata[DUTY_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read back the raw register bits.
  always_comb begin
    unique case (idx)
      REG_KP:    prdata = CFG_DW'(unsigned'(cfg_r.kp));
      REG_KI:    prdata = CFG_DW'(unsigned'(cfg_r.ki));
      REG_KD:    prdata = CFG_DW'(unsigned'(cfg_r.kd));
      REG_SCALE: prdata = CFG_DW'(cfg_r.scale);
      REG_ILIM:  prdata = CFG_DW'(cfg_r.ilimit);
      REG_DMIN:  prdata = CFG_DW'(cfg_r.duty_min);
      REG_DMAX:  prdata = CFG_DW'(cfg_r.duty_max);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/ipid_seq.sv -----
`timescale 1ns / 1ps
`include "incremental_pid_speed_regulator_defines.svh"

module ipid_seq
  import ipid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_free,
  output logic in_ready,
  output ctl_t ctl
);

  step_t pc_r;
  step_t pc_nxt;
  ctl_t  rom;
  logic  go;

  assign rom      = ucode(pc_r);
  assign in_ready = (rom.wt == W_INPUT);

  // A step runs once the condition it waits on holds.
  always_comb begin
    unique case (rom.wt)
      W_NONE:     go = 1'b1;
      W_INPUT:    go = in_valid;
      W_OUT_SLOT: go = out_free;
      default:    go = 1'b0;
    endcase
  end

  // Step counter: advance, jump, or hold while waiting.
  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      pc_nxt = rom.jmp ? rom.target : pc_r + 1'b1;
    end
  end

  // Strobes reach the datapath only when the step actually runs.
  always_comb begin
    ctl        = rom;
    ctl.in_we  = rom.in_we & go;
    ctl.mul_en = rom.mul_en & go;
    ctl.err_we = rom.err_we & go;
    ctl.int_we = rom.int_we & go;
    ctl.out_we = rom.out_we & go;
    ctl.acc_op = go ? rom.acc_op : ACC_HOLD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `IPID_ASSERT_NEXT(a_accept_starts_err, clk, rst_n, in_valid && in_ready, pc_r == STEP_ERR, "accepted item did not start the error step")
  `IPID_ASSERT(a_pc_in_program, clk, rst_n, 1'b1, pc_r < step_t'(PROG_LEN), "step counter left the program")
  `IPID_ASSERT_NEXT(a_out_returns_idle, clk, rst_n, ctl.out_we, pc_r == STEP_IDLE, "sequencer did not return to idle after result")

endmodule

// ----- rtl/core/ipid_dp.sv -----
`timescale 1ns / 1ps
`include "incremental_pid_speed_regulator_defines.svh"

module ipid_dp
  import ipid_pkg::*;
#(
  parameter int FRAC_BITS   = 12,
  parameter int SPEED_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  ctl_t               ctl,
  input  logic [SPEED_W-1:0] in_measured_rpm,
  input  logic [CODE_W-1:0]  in_set_point_code,
  input  logic               out_ready,
  output logic               out_free,
  output logic               out_valid,
  output logic [DUTY_W-1:0]  out_duty_cycle
);

  localparam int INT_W    = LIMIT_W + FRAC_BITS + 1;
  localparam int SHIFT    = FRAC_BITS + GAIN_FRAC;
  localparam int SH_L     = (FRAC_BITS >= SCALE_FRAC) ? FRAC_BITS - SCALE_FRAC : 0;
  localparam int SH_R     = (FRAC_BITS >= SCALE_FRAC) ? 0 : SCALE_FRAC - FRAC_BITS;
  localparam int SPS_W    = SPP_W + SH_L;
  localparam int RPM_W    = SPEED_W + FRAC_BITS;
  localparam int DW0      = (SPS_W > RPM_W) ? SPS_W : RPM_W;
  localparam int EW_W     = ((DW0 > ERR_W) ? DW0 : ERR_W) + 1;
  localparam int RPM_BITS = (SPEED_WIDTH < SPEED_W) ? SPEED_WIDTH : SPEED_W;
  localparam logic [SPEED_W-1:0] RPM_MASK = SPEED_W'((17'd1 << RPM_BITS) - 17'd1);

  // Payload registers.
  logic [SPEED_W-1:0]       rpm_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [OPND_W-1:0] diff_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [DUTY_W-1:0]        out_duty_r;

  // Loop state and output flag.
  logic signed [INT_W-1:0]  int_r;
  logic signed [ERR_W-1:0]  prev_r;
  logic [DUTY_W-1:0]        duty_r;
  logic                     out_valid_r;

  logic signed [GAIN_W-1:0] mul_a;
  logic signed [HI_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [OPND_W-1:0] err_ext;
  logic signed [OPND_W-1:0] int_ext;
  logic [EW_W-1:0]          sp_w;
  logic [EW_W-1:0]          rpm_w;
  logic signed [EW_W-1:0]   err_wide;
  logic                     err_fits;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [OPND_W-1:0] isum;
  logic signed [OPND_W-1:0] ilim;
  logic signed [OPND_W-1:0] ilim_neg;
  logic signed [OPND_W-1:0] iclamp;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  duty_load;
  logic signed [ACC_W-1:0]  hi_b;
  logic signed [ACC_W-1:0]  lo_b;
  logic [DUTY_W-1:0]        duty_sel;

  assign err_ext = {{(OPND_W-ERR_W){err_r[ERR_W-1]}}, err_r};
  assign int_ext = {{(OPND_W-INT_W){int_r[INT_W-1]}}, int_r};

  // Shared multiplier operand selection.
  always_comb begin
    unique case (ctl.mul_a)
      A_SCALE: mul_a = {{(GAIN_W-SCALE_W){1'b0}}, cfg.scale};
      A_KP:    mul_a = cfg.kp;
      A_KI:    mul_a = cfg.ki;
      A_KD:    mul_a = cfg.kd;
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.mul_b)
      B_CODE:    mul_b = {{(HI_W-CODE_W){1'b0}}, in_set_point_code};
      B_ERR_LO:  mul_b = {1'b0, err_ext[LO_W-1:0]};
      B_ERR_HI:  mul_b = err_ext[OPND_W-1:LO_W];
      B_INT_LO:  mul_b = {1'b0, int_ext[LO_W-1:0]};
      B_INT_HI:  mul_b = int_ext[OPND_W-1:LO_W];
      B_DIFF_LO: mul_b = {1'b0, diff_r[LO_W-1:0]};
      B_DIFF_HI: mul_b = diff_r[OPND_W-1:LO_W];
      default:   mul_b = '0;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Error: scaled set-point aligned to FRAC_BITS, minus speed, saturated.
  always_comb begin
    sp_w     = (EW_W'(prod_r[SPP_W-1:0]) << SH_L) >> SH_R;
    rpm_w    = EW_W'(rpm_r) << FRAC_BITS;
    err_wide = sp_w - rpm_w;
    err_fits = (&err_wide[EW_W-1:ERR_W-1]) | ~(|err_wide[EW_W-1:ERR_W-1]);
    if (err_fits) begin
      err_nxt = err_wide[ERR_W-1:0];
    end else if (err_wide[EW_W-1]) begin
      err_nxt = ERR_MIN;
    end else begin
      err_nxt = ERR_MAX;
    end
  end

  // Integral with anti-windup clamp.
  always_comb begin
    isum     = int_ext + err_ext;
    ilim     = OPND_W'(cfg.ilimit) << FRAC_BITS;
    ilim_neg = -ilim;
    priority if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < ilim_neg) begin
      iclamp = ilim_neg;
    end else begin
      iclamp = isum;
    end
  end

  // Accumulator of the weighted terms on top of the previous duty.
  always_comb begin
    prod_ext  = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    duty_load = ACC_W'(duty_r) << SHIFT;
    unique case (ctl.acc_op)
      ACC_HOLD:      acc_nxt = acc_r;
      ACC_LOAD_DUTY: acc_nxt = duty_load;
      ACC_ADD_LO:    acc_nxt = acc_r + prod_ext;
      ACC_ADD_HI:    acc_nxt = acc_r + (prod_ext <<< LO_W);
      default:       acc_nxt = acc_r;
    endcase
  end

  // Duty clamp; the upper bound is tested first when bounds cross.
  always_comb begin
    hi_b = ACC_W'(cfg.duty_max) << SHIFT;
    lo_b = ACC_W'(cfg.duty_min) << SHIFT;
    priority if (acc_r > hi_b) begin
      duty_sel = cfg.duty_max;
    end else if (acc_r < lo_b) begin
      duty_sel = cfg.duty_min;
    end else begin
      duty_sel = acc_r[SHIFT +: DUTY_W];
    end
  end

  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_duty_cycle = out_duty_r;

  always_ff @(posedge clk) begin
    if (ctl.in_we) begin
      rpm_r <= in_measured_rpm & RPM_MASK;
    end
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.err_we) begin
      err_r <= err_nxt;
    end
    if (ctl.int_we) begin
      diff_r <= {prev_r[ERR_W-1], prev_r} - err_ext;
    end
    if (ctl.out_we) begin
      out_duty_r <= duty_sel;
    end
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r       <= '0;
      prev_r      <= '0;
      duty_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.int_we) begin
        int_r  <= iclamp[INT_W-1:0];
        prev_r <= err_r;
      end
      if (ctl.out_we) begin
        duty_r      <= duty_sel;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `IPID_ASSERT(a_duty_in_bounds, clk, rst_n, ctl.out_we && (cfg.duty_min <= cfg.duty_max), (duty_sel >= cfg.duty_min) && (duty_sel <= cfg.duty_max), "duty outside its bounds")
  `IPID_ASSERT_NEXT(a_prev_err_follows, clk, rst_n, ctl.int_we, prev_r == $past(err_r), "previous error not updated from current error")
  `IPID_ASSERT(a_valid_from_write, clk, rst_n, $rose(out_valid_r), $past(ctl.out_we), "result shown without a duty write")

endmodule
